>>> hw/rtl/fvc_pkg.sv
package fvc_pkg;

  localparam int CACHE_ENTRIES = 32;
  localparam int ID_W          = 32;
  localparam int CNT_W         = 32;

  typedef struct packed {
    logic [ID_W-1:0] vertex_id;
    logic            face_start;
    logic            clear_first;
  } vertex_t;

  typedef struct packed {
    logic             was_hit;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] face_total;
  } result_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_UPDATE
  } fvc_state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;  // capture input item, apply clear and face count
    logic match;   // register per-entry compare vector
    logic commit;  // resolve hit, update cache and miss count, load result
  } fvc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;  // result register can take a new item this cycle
  } fvc_status_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + {{(CNT_W-1){1'b0}}, 1'b1};
  endfunction

endpackage

>>> hw/rtl/fvc_vertex_if.sv
interface fvc_vertex_if;
  logic             valid;
  logic             ready;
  fvc_pkg::vertex_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> hw/rtl/fvc_result_if.sv
interface fvc_result_if;
  logic             valid;
  logic             ready;
  fvc_pkg::result_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> hw/rtl/fvc_ctrl.sv
module fvc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  fvc_pkg::fvc_status_t status,
  output fvc_pkg::fvc_cmd_t   cmd
);
  import fvc_pkg::*;

  fvc_state_t state;
  fvc_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd.match  = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/fvc_datapath.sv
module fvc_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  fvc_pkg::fvc_cmd_t    cmd,
  output fvc_pkg::fvc_status_t status,
  input  fvc_pkg::vertex_t     in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fvc_pkg::result_t     out_data
);
  import fvc_pkg::*;

  // entry 0 is newest, entry CACHE_ENTRIES-1 oldest; misses shift in at 0
  logic [ID_W-1:0]          slot [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] slot_vld;
  logic [CACHE_ENTRIES-1:0] match_vec;
  logic [ID_W-1:0]          cur_id;
  logic [CNT_W-1:0]         miss_cnt;
  logic [CNT_W-1:0]         face_cnt;
  logic                     hit;
  logic [CNT_W-1:0]         miss_cnt_next;

  assign hit           = |match_vec;
  assign miss_cnt_next = hit ? miss_cnt : sat_inc(miss_cnt);
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_id <= in_data.vertex_id;
    end
    if (cmd.match) begin
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
        match_vec[i] <= slot_vld[i] && (slot[i] == cur_id);
      end
    end
    if (cmd.commit && !hit) begin
      slot[0] <= cur_id;
      for (int i = 1; i < CACHE_ENTRIES; i++) begin
        slot[i] <= slot[i-1];
      end
    end
    if (cmd.commit) begin
      out_data.was_hit    <= hit;
      out_data.miss_total <= miss_cnt_next;
      out_data.face_total <= face_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_vld  <= '0;
      miss_cnt  <= '0;
      face_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (in_data.clear_first) begin
          slot_vld <= '0;
          miss_cnt <= '0;
          face_cnt <= in_data.face_start ? {{(CNT_W-1){1'b0}}, 1'b1} : '0;
        end else if (in_data.face_start) begin
          face_cnt <= sat_inc(face_cnt);
        end
      end
      if (cmd.commit) begin
        miss_cnt <= miss_cnt_next;
        if (!hit) begin
          slot_vld <= {slot_vld[CACHE_ENTRIES-2:0], 1'b1};
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/fifo_vertex_cache_miss_counter.sv
// Steps: IDLE captures the input transfer, MATCH registers the compare across all
//   cache entries, and UPDATE does the hit reduction and FIFO shift and loads the result.
// A new item is taken only after the previous one has committed to the result register.
// A stalled result holds the commit step until the result register frees.
// Reset (rst, synchronous, active high): cache empty, both counters zero, no result pending.
module fifo_vertex_cache_miss_counter (
  input logic         clk,
  input logic         rst,
  fvc_vertex_if.sink  vertex,
  fvc_result_if.source result
);
  import fvc_pkg::*;

  fvc_cmd_t    cmd;
  fvc_status_t status;
  logic        ctl_ready;

  // Controller: IDLE takes a transfer, MATCH registers the compare vector,
  // UPDATE commits once the result register is free.
  fvc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vertex.valid),
    .in_ready (ctl_ready),
    .status   (status),
    .cmd      (cmd)
  );

  assign vertex.ready = ctl_ready;

  // Datapath: entry shift line with valid bits, per-entry comparators,
  // saturating miss and face counters and the result register.
  fvc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (vertex.data),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data)
  );

  // A commit always lands a result in the output register.
  a_commit_loads: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> result.valid)
    else $error("commit did not load result");

  // A reported miss means the miss counter has moved off zero.
  a_miss_counts: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.data.was_hit) |-> (result.data.miss_total != '0))
    else $error("miss reported with zero miss total");

  // One item in flight: no new transfer the cycle after one is taken.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (vertex.valid && vertex.ready) |=> !vertex.ready)
    else $error("input accepted while item in flight");

  // Controller issues at most one command per cycle.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.accept, cmd.match, cmd.commit}))
    else $error("overlapping commands");

endmodule
